// ===== src/rtlm_pkg.sv =====
package rtlm_pkg;

    localparam int RowCount  = 1024;
    localparam int WaitSlots = 4;

    typedef enum logic [3:0] {
        OP_READ        = 4'd0,
        OP_WRITE       = 4'd1,
        OP_RENEW       = 4'd2,
        OP_SET_TS      = 4'd3,
        OP_LOCK        = 4'd4,
        OP_RELEASE     = 4'd5,
        OP_DELETE      = 4'd6,
        OP_UPDATE_RTS  = 4'd7,
        OP_UPDATE_DATA = 4'd8
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ABORT   = 3'd1,
        ST_WAIT    = 3'd2,
        ST_FINISH  = 3'd3,
        ST_IGNORED = 3'd4
    } t_status;

    localparam logic [1:0] CFG_WAIT_MODE   = 2'd0;
    localparam logic [1:0] CFG_LEADER_ROLE = 2'd1;
    localparam logic [1:0] CFG_MAX_WAITERS = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCAN,
        S_EXEC,
        S_WRITE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [31:0] id;
        logic [31:0] prio;
    } t_waiter;

endpackage

// ===== src/row_timestamp_lock_manager_core.sv =====
// Row timestamp lock manager. One operation word is taken at a time; the row
// it names is read from the row store, the wait slots of the row are walked
// through a single compare unit, one slot per cycle, then the row is written
// back (scan and write-back for in-range rows only) and the result word is
// presented. The next word can be taken in the cycle after the result leaves;
// the result is held while stall is high.
// After reset the row store is swept clear, one row per cycle; no operation
// word is taken until the sweep ends. Configuration writes are taken at any
// time. A row index at or above ROW_COUNT reports status ignored.
module row_timestamp_lock_manager_core #(
    parameter int ROW_COUNT  = rtlm_pkg::RowCount,
    parameter int WAIT_SLOTS = rtlm_pkg::WaitSlots
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_opcode,
    input  logic [9:0]  i_row_index,
    input  logic [31:0] i_txn_id,
    input  logic [31:0] i_txn_priority,
    input  logic        i_txn_is_applier,
    input  logic [63:0] i_commit_ts,
    input  logic [63:0] i_ts_write,
    input  logic [63:0] i_ts_read,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [63:0] o_row_wts,
    output logic [63:0] o_row_rts,
    output logic        o_wakeup_valid,
    output logic [31:0] o_wakeup_txn
);
    import rtlm_pkg::*;

    localparam int AW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int SW = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
    localparam int CW = $clog2(WAIT_SLOTS + 1);
    localparam int KW = AW + 1;

    typedef struct packed {
        logic [63:0] wts;
        logic [63:0] rts;
        logic        del;
        logic [63:0] dts;
        logic        own;
        logic [31:0] oid;
        logic [31:0] oprio;
    } t_row;

    t_row    mem_row [ROW_COUNT];
    t_waiter mem_wait [ROW_COUNT][WAIT_SLOTS];

    t_state r_state, n_state;
    logic   r_wait_mode, r_leader, r_busy;
    logic [2:0] r_max_waiters;
    logic [KW-1:0] r_clr, n_clr;

    logic [3:0]  r_op;
    logic [AW-1:0] r_row;
    logic        r_oor;
    logic [31:0] r_id, r_prio;
    logic        r_app;
    logic [63:0] r_cts, r_tw, r_tr;

    t_row    r_rec, n_rec;
    t_waiter r_w [WAIT_SLOTS];
    t_waiter n_w [WAIT_SLOTS];
    logic [SW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_cnt, n_cnt;
    logic        r_fnd, n_fnd;
    logic [SW-1:0] r_fpos, n_fpos;
    logic        r_bst, n_bst;
    logic [SW-1:0] r_bpos, n_bpos;
    logic [2:0]  r_st, n_st;
    logic        r_wk, n_wk;
    logic [31:0] r_wid, n_wid;
    logic        r_ovalid, n_ovalid;

    logic        accept;
    logic [CW-1:0] limit;
    t_waiter     cur;
    logic        rm_en;
    logic [SW-1:0] rm_pos;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign cur     = r_w[r_idx];
    assign limit   = ({1'b0, r_max_waiters} > (CW+1)'(WAIT_SLOTS))
                     ? CW'(WAIT_SLOTS) : CW'(r_max_waiters);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_mode   <= 1'b1;
            r_leader      <= 1'b1;
            r_max_waiters <= 3'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WAIT_MODE:   r_wait_mode   <= i_cfg_data[0];
                CFG_LEADER_ROLE: r_leader      <= i_cfg_data[0];
                CFG_MAX_WAITERS: r_max_waiters <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_busy   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
            r_busy   <= (n_state != S_IDLE) && (n_state != S_CLEAR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_opcode;
            r_row  <= AW'(i_row_index);
            r_oor  <= ({22'd0, i_row_index} >= 32'(ROW_COUNT));
            r_id   <= i_txn_id;
            r_prio <= i_txn_priority;
            r_app  <= i_txn_is_applier;
            r_cts  <= i_commit_ts;
            r_tw   <= i_ts_write;
            r_tr   <= i_ts_read;
        end
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        r_fnd  <= n_fnd;
        r_fpos <= n_fpos;
        r_bst  <= n_bst;
        r_bpos <= n_bpos;
        r_st   <= n_st;
        r_wk   <= n_wk;
        r_wid  <= n_wid;
        if (r_state == S_READ) begin
            r_rec <= mem_row[r_row];
            for (int i = 0; i < WAIT_SLOTS; i++) r_w[i] <= mem_wait[r_row][i];
        end else begin
            r_rec <= n_rec;
            for (int i = 0; i < WAIT_SLOTS; i++) r_w[i] <= n_w[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            mem_row[r_clr[AW-1:0]] <= '0;
            for (int i = 0; i < WAIT_SLOTS; i++) mem_wait[r_clr[AW-1:0]][i] <= '0;
        end else if (r_state == S_WRITE && !r_oor) begin
            mem_row[r_row] <= r_rec;
            for (int i = 0; i < WAIT_SLOTS; i++) mem_wait[r_row][i] <= r_w[i];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_fnd    = r_fnd;
        n_fpos   = r_fpos;
        n_bst    = r_bst;
        n_bpos   = r_bpos;
        n_st     = r_st;
        n_wk     = r_wk;
        n_wid    = r_wid;
        n_rec    = r_rec;
        n_ovalid = r_ovalid;
        for (int i = 0; i < WAIT_SLOTS; i++) n_w[i] = r_w[i];
        rm_en  = 1'b0;
        rm_pos = '0;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == KW'(ROW_COUNT - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = S_READ;
            end
            S_READ: begin
                n_idx = '0;
                n_cnt = '0;
                n_fnd = 1'b0;
                n_bst = 1'b0;
                n_fpos = '0;
                n_bpos = '0;
                n_state = r_oor ? S_EXEC : S_SCAN;
            end
            S_SCAN: begin
                if (cur.valid) begin
                    n_cnt = r_cnt + 1'b1;
                    if (!r_fnd && cur.id == r_id) begin
                        n_fnd = 1'b1;
                        n_fpos = r_idx;
                    end
                    if (!r_bst || cur.prio > r_w[r_bpos].prio) begin
                        n_bst = 1'b1;
                        n_bpos = r_idx;
                    end
                end
                if (r_idx == SW'(WAIT_SLOTS - 1)) n_state = S_EXEC;
                else n_idx = r_idx + 1'b1;
            end
            S_EXEC: begin
                n_st  = ST_OK;
                n_wk  = 1'b0;
                n_wid = '0;
                n_state = S_WRITE;
                if (r_oor) begin
                    n_st = ST_IGNORED;
                    n_rec.wts = '0;
                    n_rec.rts = '0;
                end else begin
                    case (r_op)
                        OP_READ: ;
                        OP_WRITE: begin
                            if (!r_leader && r_tw <= r_rec.rts) n_st = ST_IGNORED;
                            else begin
                                n_rec.wts = r_tw;
                                n_rec.rts = r_tw;
                            end
                        end
                        OP_RENEW: begin
                            if (r_tw != r_rec.wts) n_st = ST_ABORT;
                            else if (r_tr <= r_rec.rts) n_st = ST_OK;
                            else if (r_rec.own && r_rec.oid != r_id) n_st = ST_ABORT;
                            else if (r_rec.del)
                                n_st = (r_tr < r_rec.dts) ? ST_OK : ST_ABORT;
                            else n_rec.rts = r_tr;
                        end
                        OP_SET_TS: begin
                            n_rec.wts = r_tw;
                            n_rec.rts = r_tr;
                        end
                        OP_LOCK: begin
                            if (r_app && r_cts < r_rec.wts) n_st = ST_FINISH;
                            else if (r_rec.own && r_rec.oid == r_id) n_st = ST_OK;
                            else if (!r_rec.own) begin
                                n_rec.own = 1'b1;
                                n_rec.oid = r_id;
                                n_rec.oprio = r_prio;
                            end else if (!r_app && !r_wait_mode) n_st = ST_ABORT;
                            else if (r_fnd) n_st = ST_WAIT;
                            else if (r_cnt >= (r_app ? CW'(WAIT_SLOTS) : limit))
                                n_st = ST_ABORT;
                            else if (r_app || r_prio < r_rec.oprio) begin
                                n_st = ST_WAIT;
                                n_w[r_cnt[SW-1:0]] = '{valid: 1'b1, id: r_id, prio: r_prio};
                            end else n_st = ST_ABORT;
                        end
                        OP_RELEASE: begin
                            if (!r_wait_mode) begin
                                if (r_rec.own && r_rec.oid == r_id) n_rec.own = 1'b0;
                            end else if (!(r_rec.own && r_rec.oid == r_id)) begin
                                rm_en  = r_fnd;
                                rm_pos = r_fpos;
                            end else if (!r_bst) begin
                                n_rec.own = 1'b0;
                                n_rec.oid = '0;
                                n_rec.oprio = '0;
                            end else begin
                                n_rec.own = 1'b1;
                                n_rec.oid = r_w[r_bpos].id;
                                n_rec.oprio = r_w[r_bpos].prio;
                                n_wk  = 1'b1;
                                n_wid = r_w[r_bpos].id;
                                rm_en  = 1'b1;
                                rm_pos = r_bpos;
                            end
                        end
                        OP_DELETE: begin
                            n_rec.del = 1'b1;
                            n_rec.dts = r_tw;
                        end
                        OP_UPDATE_RTS: begin
                            if (r_tw > r_rec.wts) n_st = ST_ABORT;
                            else if (r_tw == r_rec.wts && r_tr > r_rec.rts)
                                n_rec.rts = r_tr;
                        end
                        OP_UPDATE_DATA: begin
                            if (r_tw >= r_rec.wts) begin
                                n_rec.wts = r_tw;
                                n_rec.rts = r_tw;
                            end
                        end
                        default: n_st = ST_IGNORED;
                    endcase
                end
                if (rm_en) begin
                    for (int i = 0; i < WAIT_SLOTS; i++) begin
                        if (i >= int'(rm_pos)) begin
                            if (i + 1 < WAIT_SLOTS) n_w[i] = r_w[(i + 1) % WAIT_SLOTS];
                            else n_w[i] = '0;
                        end
                    end
                end
            end
            S_WRITE: begin
                n_ovalid = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_ovalid = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_st;
    assign o_row_wts      = r_rec.wts;
    assign o_row_rts      = r_rec.rts;
    assign o_wakeup_valid = r_wk;
    assign o_wakeup_txn   = r_wid;

    a_out_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_OUT))
        else $error("result word outside output state");
    a_wake_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_wakeup_valid) |-> (o_wakeup_txn == '0))
        else $error("wakeup id without wakeup");
    a_wake_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_wakeup_valid) |-> (r_op == OP_RELEASE && o_status == ST_OK))
        else $error("wakeup from non-release");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> o_stall)
        else $error("input taken while busy");
endmodule

// ===== tb/tb_row_timestamp_lock_manager_core.sv =====
module tb_row_timestamp_lock_manager_core;
    import rtlm_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] wts;
        logic [63:0] rts;
        logic        wake;
        logic [31:0] wake_id;
    } t_row_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [2:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [3:0]  i_opcode = '0;
    logic [9:0]  i_row_index = '0;
    logic [31:0] i_txn_id = '0;
    logic [31:0] i_txn_priority = '0;
    logic        i_txn_is_applier = 1'b0;
    logic [63:0] i_commit_ts = '0;
    logic [63:0] i_ts_write = '0;
    logic [63:0] i_ts_read = '0;
    logic        o_valid;
    logic        i_stall = 1'b1;
    logic [2:0]  o_status;
    logic [63:0] o_row_wts;
    logic [63:0] o_row_rts;
    logic        o_wakeup_valid;
    logic [31:0] o_wakeup_txn;

    row_timestamp_lock_manager_core uut (.*);

    always #5 i_clk = ~i_clk;

    logic [63:0] wstamp [RowCount];
    logic [63:0] rstamp [RowCount];
    logic        dflag [RowCount];
    logic [63:0] dstamp [RowCount];
    logic        own_v [RowCount];
    logic [31:0] own_id [RowCount];
    logic [31:0] own_pr [RowCount];
    t_waiter     waitq [RowCount][WaitSlots];
    logic        m_wait_mode = 1'b1;
    logic        m_leader = 1'b1;
    logic [2:0]  m_max_waiters = 3'd4;

    t_row_result pending_results[$];
    int          mismatches = 0;
    longint      cycles = 0;
    bit          hold_off = 1'b0;
    bit          stall_random = 1'b1;

    function automatic int waiter_slot(int r, logic [31:0] id);
        for (int i = 0; i < WaitSlots; i++)
            if (waitq[r][i].valid && waitq[r][i].id == id) return i;
        return -1;
    endfunction

    function automatic int waiter_count(int r);
        int n;
        n = 0;
        for (int i = 0; i < WaitSlots; i++)
            if (waitq[r][i].valid) n++;
        return n;
    endfunction

    function automatic void waiter_drop(int r, int slot);
        if (slot < 0) return;
        for (int i = slot; i + 1 < WaitSlots; i++) waitq[r][i] = waitq[r][i + 1];
        waitq[r][WaitSlots - 1] = '0;
    endfunction

    function automatic void waiter_push(int r, logic [31:0] id, logic [31:0] pr);
        int n;
        n = waiter_count(r);
        if (n < WaitSlots) waitq[r][n] = '{1'b1, id, pr};
    endfunction

    function automatic t_status lock_outcome(int r, logic [31:0] id, logic [31:0] pr,
                                             logic app, logic [63:0] cts);
        int lim;
        if (app && cts < wstamp[r]) return ST_FINISH;
        if (own_v[r] && own_id[r] == id) return ST_OK;
        if (!own_v[r]) begin
            own_v[r] = 1'b1;
            own_id[r] = id;
            own_pr[r] = pr;
            return ST_OK;
        end
        if (!app) begin
            if (!m_wait_mode) return ST_ABORT;
            if (waiter_slot(r, id) >= 0) return ST_WAIT;
            lim = (int'(m_max_waiters) > WaitSlots) ? WaitSlots : int'(m_max_waiters);
            if (waiter_count(r) >= lim) return ST_ABORT;
            if (pr < own_pr[r]) begin
                waiter_push(r, id, pr);
                return ST_WAIT;
            end
            return ST_ABORT;
        end
        if (waiter_slot(r, id) >= 0) return ST_WAIT;
        if (waiter_count(r) >= WaitSlots) return ST_ABORT;
        waiter_push(r, id, pr);
        return ST_WAIT;
    endfunction

    function automatic t_row_result row_outcome(logic [3:0] op, logic [9:0] row,
            logic [31:0] id, logic [31:0] pr, logic app, logic [63:0] cts,
            logic [63:0] tw, logic [63:0] tr);
        t_row_result res;
        int r;
        int best;
        res = '0;
        res.status = ST_OK;
        if (int'(row) >= RowCount) begin
            res.status = ST_IGNORED;
            return res;
        end
        r = int'(row);
        case (op)
            OP_READ: ;
            OP_WRITE: begin
                if (!m_leader && tw <= rstamp[r]) res.status = ST_IGNORED;
                else begin
                    wstamp[r] = tw;
                    rstamp[r] = tw;
                end
            end
            OP_RENEW: begin
                if (tw != wstamp[r]) res.status = ST_ABORT;
                else if (tr <= rstamp[r]) res.status = ST_OK;
                else if (own_v[r] && own_id[r] != id) res.status = ST_ABORT;
                else if (dflag[r]) res.status = (tr < dstamp[r]) ? ST_OK : ST_ABORT;
                else rstamp[r] = tr;
            end
            OP_SET_TS: begin
                wstamp[r] = tw;
                rstamp[r] = tr;
            end
            OP_LOCK: res.status = lock_outcome(r, id, pr, app, cts);
            OP_RELEASE: begin
                if (!m_wait_mode) begin
                    if (own_v[r] && own_id[r] == id) own_v[r] = 1'b0;
                end else if (!(own_v[r] && own_id[r] == id)) begin
                    waiter_drop(r, waiter_slot(r, id));
                end else begin
                    best = -1;
                    for (int i = 0; i < WaitSlots; i++)
                        if (waitq[r][i].valid &&
                            (best < 0 || waitq[r][i].prio > waitq[r][best].prio)) best = i;
                    if (best < 0) begin
                        own_v[r] = 1'b0;
                        own_id[r] = '0;
                        own_pr[r] = '0;
                    end else begin
                        own_v[r] = 1'b1;
                        own_id[r] = waitq[r][best].id;
                        own_pr[r] = waitq[r][best].prio;
                        res.wake = 1'b1;
                        res.wake_id = waitq[r][best].id;
                        waiter_drop(r, best);
                    end
                end
            end
            OP_DELETE: begin
                dflag[r] = 1'b1;
                dstamp[r] = tw;
            end
            OP_UPDATE_RTS: begin
                if (tw > wstamp[r]) res.status = ST_ABORT;
                else if (tw == wstamp[r] && tr > rstamp[r]) rstamp[r] = tr;
            end
            OP_UPDATE_DATA: begin
                if (tw >= wstamp[r]) begin
                    wstamp[r] = tw;
                    rstamp[r] = tw;
                end
            end
            default: res.status = ST_IGNORED;
        endcase
        res.wts = wstamp[r];
        res.rts = rstamp[r];
        return res;
    endfunction

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_word(logic [3:0] op, logic [9:0] row, logic [31:0] id,
            logic [31:0] pr, logic app, logic [63:0] cts, logic [63:0] tw,
            logic [63:0] tr, bit gaps = 1'b1);
        @(posedge i_clk);
        if (gaps) idle_gap();
        i_valid <= 1'b1;
        i_opcode <= op;
        i_row_index <= row;
        i_txn_id <= id;
        i_txn_priority <= pr;
        i_txn_is_applier <= app;
        i_commit_ts <= cts;
        i_ts_write <= tw;
        i_ts_read <= tr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(row_outcome(op, row, id, pr, app, cts, tw, tr));
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [2:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_WAIT_MODE:   m_wait_mode = val[0];
            CFG_LEADER_ROLE: m_leader = val[0];
            default:         m_max_waiters = val;
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] small_ts();
        return ($urandom_range(0, 15) == 0) ? rand64() : 64'($urandom_range(0, 20));
    endfunction

    task automatic random_word(int rows, bit gaps = 1'b1);
        logic [3:0] op;
        logic [9:0] row;
        op = ($urandom_range(0, 30) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
        if ($urandom_range(0, 2) == 0) op = OP_LOCK;
        else if ($urandom_range(0, 3) == 0) op = OP_RELEASE;
        row = ($urandom_range(0, 20) == 0) ? 10'($urandom()) : 10'($urandom_range(0, rows));
        send_word(op, row, 32'($urandom_range(1, 8)),
                  ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 12)),
                  1'($urandom_range(0, 3) == 0), small_ts(), small_ts(), small_ts(), gaps);
    endtask

    task automatic test_directed();
        send_word(OP_READ, 10'd1023, '0, '0, 1'b0, '0, '0, '0);
        send_word(OP_SET_TS, 10'd0, '1, '1, 1'b1, '1, '1, '1);
        send_word(OP_WRITE, 10'd1, '0, '0, 1'b0, '0, 64'd10, '0);
        send_word(OP_RENEW, 10'd1, 32'd1, '0, 1'b0, '0, 64'd9, 64'd20);
        send_word(OP_RENEW, 10'd1, 32'd1, '0, 1'b0, '0, 64'd10, 64'd5);
        send_word(OP_RENEW, 10'd1, 32'd1, '0, 1'b0, '0, 64'd10, 64'd20);
        send_word(OP_DELETE, 10'd1, '0, '0, 1'b0, '0, 64'd25, '0);
        send_word(OP_RENEW, 10'd1, 32'd1, '0, 1'b0, '0, 64'd10, 64'd24);
        send_word(OP_RENEW, 10'd1, 32'd1, '0, 1'b0, '0, 64'd10, 64'd30);
        send_word(OP_UPDATE_RTS, 10'd1, '0, '0, 1'b0, '0, 64'd11, '0);
        send_word(OP_UPDATE_RTS, 10'd1, '0, '0, 1'b0, '0, 64'd10, 64'd40);
        send_word(OP_UPDATE_DATA, 10'd1, '0, '0, 1'b0, '0, 64'd3, '0);
        send_word(OP_UPDATE_DATA, 10'd1, '0, '0, 1'b0, '0, 64'd50, '0);
        send_word(4'hF, 10'd1, '0, '0, 1'b0, '0, '0, '0);
        send_word(OP_LOCK, 10'd2, 32'd1, 32'd10, 1'b0, '0, '0, '0);
        send_word(OP_LOCK, 10'd2, 32'd2, 32'd5, 1'b0, '0, '0, '0);
        send_word(OP_LOCK, 10'd2, 32'd2, 32'd5, 1'b0, '0, '0, '0);
        send_word(OP_LOCK, 10'd2, 32'd3, 32'd5, 1'b0, '0, '0, '0);
        send_word(OP_LOCK, 10'd2, 32'd4, 32'd20, 1'b0, '0, '0, '0);
        send_word(OP_LOCK, 10'd2, 32'd5, 32'd1, 1'b1, '1, '0, '0);
        send_word(OP_LOCK, 10'd2, 32'd6, 32'd1, 1'b1, '1, '0, '0);
        send_word(OP_LOCK, 10'd2, 32'd7, 32'd1, 1'b1, '1, '0, '0);
        send_word(OP_LOCK, 10'd0, 32'd8, 32'd1, 1'b1, '0, '0, '0);
        send_word(OP_RELEASE, 10'd2, 32'd3, '0, 1'b0, '0, '0, '0);
        send_word(OP_RELEASE, 10'd2, 32'd1, '0, 1'b0, '0, '0, '0);
    endtask

    task automatic test_random(int count, int rows);
        repeat (count) random_word(rows);
    endtask

    task automatic test_config_sweep();
        write_reg(CFG_WAIT_MODE, 3'd0);
        test_random(250, 6);
        write_reg(CFG_WAIT_MODE, 3'd1);
        write_reg(CFG_MAX_WAITERS, 3'd0);
        test_random(150, 6);
        write_reg(CFG_MAX_WAITERS, 3'd7);
        write_reg(CFG_LEADER_ROLE, 3'd0);
        test_random(250, 6);
        write_reg(CFG_LEADER_ROLE, 3'd1);
        write_reg(CFG_MAX_WAITERS, 3'd2);
        test_random(250, 8);
        write_reg(CFG_MAX_WAITERS, 3'd4);
    endtask

    task automatic test_backpressure();
        drain();
        hold_off = 1'b1;
        repeat (12) random_word(4, 1'b0);
        drain();
        test_random(100, 1023);
    endtask

    always @(posedge i_clk) begin
        if (hold_off) begin
            i_stall <= 1'b1;
            repeat (300) @(posedge i_clk);
            hold_off <= 1'b0;
            i_stall <= 1'b0;
        end else if (!i_rst_n) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 7) == 0) ||
                       ($urandom_range(0, 60) == 0 && stall_random);
        end
    end

    always @(posedge i_clk) begin
        t_row_result got;
        t_row_result want;
        cycles++;
        if (cycles > 400000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_status, o_row_wts, o_row_rts, o_wakeup_valid, o_wakeup_txn};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("expected %p got %p", want, got);
                end
            end
        end
    end

    initial begin
        for (int r = 0; r < RowCount; r++) begin
            wstamp[r] = '0; rstamp[r] = '0; dflag[r] = 1'b0; dstamp[r] = '0;
            own_v[r] = 1'b0; own_id[r] = '0; own_pr[r] = '0;
            for (int s = 0; s < WaitSlots; s++) waitq[r][s] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(300, 10);
        test_config_sweep();
        test_backpressure();
        test_random(560, 12);
        drain();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
src/rtlm_pkg.sv
src/row_timestamp_lock_manager_core.sv
tb/tb_row_timestamp_lock_manager_core.sv
